### rtl/core/rbs_pkg.sv
// Shared types and constants for the ray versus box slab test.
`default_nettype none
package rbs_pkg;

  localparam int unsigned QBITS = 32;
  // Divider input register, one register per quotient bit, lane output register.
  localparam int unsigned LANE_LAT = QBITS + 2;
  localparam int unsigned AXES = 3;

  localparam logic [2:0] REG_BOX_MIN_X = 3'd0;
  localparam logic [2:0] REG_BOX_MIN_Y = 3'd1;
  localparam logic [2:0] REG_BOX_MIN_Z = 3'd2;
  localparam logic [2:0] REG_BOX_MAX_X = 3'd3;
  localparam logic [2:0] REG_BOX_MAX_Y = 3'd4;
  localparam logic [2:0] REG_BOX_MAX_Z = 3'd5;

  localparam logic [1:0] FACE_NONE = 2'd3;

  localparam logic signed [31:0] T_POS_INF = 32'sh7fff_ffff;
  localparam logic signed [31:0] T_NEG_INF = 32'sh8000_0000;

  typedef struct packed {
    logic signed [31:0] ray_pos_x;
    logic signed [31:0] ray_pos_y;
    logic signed [31:0] ray_pos_z;
    logic signed [31:0] ray_dir_x;
    logic signed [31:0] ray_dir_y;
    logic signed [31:0] ray_dir_z;
  } in_item_t;

  typedef struct packed {
    logic               hit;
    logic signed [31:0] entry_time;
    logic signed [31:0] exit_time;
    logic [1:0]         face_axis;
    logic               face_negative;
  } out_item_t;

  typedef struct packed {
    logic dzero;
    logic dpos;
    logic in_slab;
  } lane_flags_t;

  typedef struct packed {
    logic signed [31:0] t1;
    logic signed [31:0] t2;
    lane_flags_t        flags;
  } lane_res_t;

endpackage
`default_nettype wire

### rtl/core/rbs_slab_div.sv
// Pipelined saturating Q16.16 divider, one quotient bit per stage.
`default_nettype none
module rbs_slab_div
  import rbs_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic signed [32:0] diff_i,
  input  wire logic signed [31:0] dir_i,
  output logic signed [31:0]      t_o
);

  logic [32:0] dmag;
  logic [31:0] vmag;
  logic        ovf_in;

  logic [31:0] rem_r  [0:QBITS];
  logic [31:0] low_r  [0:QBITS];
  logic [31:0] quo_r  [0:QBITS];
  logic [31:0] vm_r   [0:QBITS];
  logic        neg_r  [0:QBITS];
  logic        ovf_r  [0:QBITS];

  always_comb begin
    dmag   = diff_i[32] ? (~diff_i + 33'd1) : diff_i;
    vmag   = dir_i[31] ? (~dir_i + 32'd1) : dir_i;
    // The quotient reaches 2^32 when the top 17 numerator bits already cover the divisor.
    ovf_in = {15'd0, dmag[32:16]} >= vmag;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= {15'd0, dmag[32:16]};
      low_r[0] <= {dmag[15:0], 16'd0};
      quo_r[0] <= '0;
      vm_r[0]  <= vmag;
      neg_r[0] <= diff_i[32] ^ dir_i[31];
      ovf_r[0] <= ovf_in;
    end
  end

  for (genvar k = 0; k < QBITS; k++) begin : g_step
    logic [32:0] r2;
    logic        ge;
    always_comb begin
      r2 = {rem_r[k], low_r[k][31]};
      ge = r2 >= {1'b0, vm_r[k]};
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+1] <= ge ? 32'(r2 - {1'b0, vm_r[k]}) : r2[31:0];
        low_r[k+1] <= {low_r[k][30:0], 1'b0};
        quo_r[k+1] <= {quo_r[k][30:0], ge};
        vm_r[k+1]  <= vm_r[k];
        neg_r[k+1] <= neg_r[k];
        ovf_r[k+1] <= ovf_r[k];
      end
    end
  end

  always_comb begin
    if (neg_r[QBITS]) begin
      if (ovf_r[QBITS] || (quo_r[QBITS] > 32'h8000_0000)) begin
        t_o = T_NEG_INF;
      end else begin
        t_o = ~quo_r[QBITS] + 32'd1;
      end
    end else begin
      if (ovf_r[QBITS] || quo_r[QBITS][31]) begin
        t_o = T_POS_INF;
      end else begin
        t_o = quo_r[QBITS];
      end
    end
  end

endmodule
`default_nettype wire

### rtl/core/rbs_axis_lane.sv
// One axis lane: two slab distances, their ordering and the zero-direction test.
`default_nettype none
module rbs_axis_lane
  import rbs_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic signed [31:0] lo_i,
  input  wire logic signed [31:0] hi_i,
  input  wire logic signed [31:0] pos_i,
  input  wire logic signed [31:0] dir_i,
  output lane_res_t               res_o
);

  logic signed [32:0] diff_lo;
  logic signed [32:0] diff_hi;
  logic signed [31:0] t_lo;
  logic signed [31:0] t_hi;
  lane_flags_t        flags_in;
  lane_flags_t        flags_r [0:QBITS];
  lane_res_t          res_r;

  always_comb begin
    diff_lo          = {lo_i[31], lo_i} - {pos_i[31], pos_i};
    diff_hi          = {hi_i[31], hi_i} - {pos_i[31], pos_i};
    flags_in.dzero   = dir_i == '0;
    flags_in.dpos    = !dir_i[31] && (dir_i != '0);
    flags_in.in_slab = (pos_i <= hi_i) && (pos_i >= lo_i);
  end

  rbs_slab_div u_div_lo (
    .clk    (clk),
    .en     (en),
    .diff_i (diff_lo),
    .dir_i  (dir_i),
    .t_o    (t_lo)
  );

  rbs_slab_div u_div_hi (
    .clk    (clk),
    .en     (en),
    .diff_i (diff_hi),
    .dir_i  (dir_i),
    .t_o    (t_hi)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      flags_r[0] <= flags_in;
      for (int k = 1; k <= QBITS; k++) begin
        flags_r[k] <= flags_r[k-1];
      end
      res_r.flags <= flags_r[QBITS];
      if (t_lo > t_hi) begin
        res_r.t1 <= t_hi;
        res_r.t2 <= t_lo;
      end else begin
        res_r.t1 <= t_lo;
        res_r.t2 <= t_hi;
      end
    end
  end

  assign res_o = res_r;

endmodule
`default_nettype wire

### rtl/core/rbs_merge.sv
// Merges the three axis lanes into the entry and exit distances and the entry face.
`default_nettype none
module rbs_merge
  import rbs_pkg::*;
(
  input  wire lane_res_t lane_i [0:AXES-1],
  output out_item_t      item_o
);

  logic signed [31:0] tnear;
  logic signed [31:0] tfar;
  logic [1:0]         axis;
  logic               neg;
  logic               miss;

  always_comb begin
    tnear = T_NEG_INF;
    tfar  = T_POS_INF;
    axis  = FACE_NONE;
    neg   = 1'b0;
    miss  = 1'b0;
    // Once a miss is seen the result is all zeros, so later axes need not be masked.
    for (int u = 0; u < AXES; u++) begin
      if (lane_i[u].flags.dzero) begin
        if (!lane_i[u].flags.in_slab) begin
          miss = 1'b1;
        end
      end else begin
        if (lane_i[u].t1 > tnear) begin
          tnear = lane_i[u].t1;
          axis  = 2'(u);
          neg   = lane_i[u].flags.dpos;
        end
        if (lane_i[u].t2 < tfar) begin
          tfar = lane_i[u].t2;
        end
        if (tnear > tfar) begin
          miss = 1'b1;
        end
      end
    end
    if (miss || !(tnear > 0)) begin
      item_o.hit           = 1'b0;
      item_o.entry_time    = '0;
      item_o.exit_time     = '0;
      item_o.face_axis     = FACE_NONE;
      item_o.face_negative = 1'b0;
    end else begin
      item_o.hit           = 1'b1;
      item_o.entry_time    = tnear;
      item_o.exit_time     = tfar;
      item_o.face_axis     = axis;
      item_o.face_negative = neg;
    end
  end

endmodule
`default_nettype wire

### rtl/core/ray_box_slab_intersect_core.sv
// Top level of the ray versus axis-aligned box slab test.
//
//   channel  ports                             payload
//   input    in_valid / in_ready / in_item     in_item_t, ray origin and direction
//   result   out_valid / out_ready / out_item  out_item_t, hit, times, entry face
//   config   cfg_valid / cfg_ready             cfg_index, cfg_data (box corners)
//
// One request is taken per cycle unless halted; a result passes the input register,
// the 32 one-bit divider stages, the lane output register and the output register.
// Reset clears the box corners to zero and empties the pipeline.
// The pipeline halts only when its last stage holds a result and the output
// register is full and not taken; otherwise it advances every cycle, bubbles included.
`default_nettype none
module ray_box_slab_intersect_core
  import rbs_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire in_item_t    in_item,
  output logic             out_valid,
  input  wire logic        out_ready,
  output out_item_t        out_item,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  logic signed [31:0] lo_r [0:AXES-1];
  logic signed [31:0] hi_r [0:AXES-1];
  logic [LANE_LAT-1:0] vld_r;
  logic               out_valid_r;
  out_item_t          out_item_r;
  logic               en;
  logic signed [31:0] pos [0:AXES-1];
  logic signed [31:0] dir [0:AXES-1];
  lane_res_t          lane_res [0:AXES-1];
  out_item_t          merged;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int a = 0; a < AXES; a++) begin
        lo_r[a] <= '0;
        hi_r[a] <= '0;
      end
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_BOX_MIN_X: lo_r[0] <= cfg_data;
        REG_BOX_MIN_Y: lo_r[1] <= cfg_data;
        REG_BOX_MIN_Z: lo_r[2] <= cfg_data;
        REG_BOX_MAX_X: hi_r[0] <= cfg_data;
        REG_BOX_MAX_Y: hi_r[1] <= cfg_data;
        REG_BOX_MAX_Z: hi_r[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  assign en       = !(vld_r[LANE_LAT-1] && out_valid_r && !out_ready);
  assign in_ready = en;

  assign pos[0] = in_item.ray_pos_x;
  assign pos[1] = in_item.ray_pos_y;
  assign pos[2] = in_item.ray_pos_z;
  assign dir[0] = in_item.ray_dir_x;
  assign dir[1] = in_item.ray_dir_y;
  assign dir[2] = in_item.ray_dir_z;

  for (genvar a = 0; a < AXES; a++) begin : g_lane
    rbs_axis_lane u_lane (
      .clk   (clk),
      .en    (en),
      .lo_i  (lo_r[a]),
      .hi_i  (hi_r[a]),
      .pos_i (pos[a]),
      .dir_i (dir[a]),
      .res_o (lane_res[a])
    );
  end

  rbs_merge u_merge (
    .lane_i (lane_res),
    .item_o (merged)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LANE_LAT-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ready) begin
      out_valid_r <= vld_r[LANE_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_ready) begin
      out_item_r <= merged;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule
`default_nettype wire

### rtl/core/rbs_checker.sv
// Port-level assertions for the slab test core and their binding.
`default_nettype none
module rbs_checker
  import rbs_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_item_t out_item
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result changed while stalled");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.hit |-> out_item.entry_time == 0 && out_item.exit_time == 0
      && out_item.face_axis == FACE_NONE && !out_item.face_negative)
    else $error("miss result not cleared");

  a_hit_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.hit |-> out_item.entry_time > 0
      && out_item.entry_time <= out_item.exit_time && out_item.face_axis != FACE_NONE)
    else $error("hit result inconsistent");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind ray_box_slab_intersect_core rbs_checker u_rbs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);
`default_nettype wire

### bench/ray_box_slab_intersect_core_tb.sv
// Self-checking testbench for the ray versus axis-aligned box slab test.
`default_nettype none
module ray_box_slab_intersect_core_tb;
  import rbs_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_item = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_item;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  ray_box_slab_intersect_core dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic signed [31:0] box_lo [3];
  logic signed [31:0] box_hi [3];
  out_item_t hits_pending [$];
  int unsigned mismatches = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_cycles = 0;
  longint unsigned cycle_count = 0;

  // Quotient of (corner - origin) * 2^16 / dir, truncated and saturated.
  function automatic logic signed [31:0] slab_dist(logic signed [31:0] corner,
                                                   logic signed [31:0] origin,
                                                   logic signed [31:0] dir);
    longint num;
    longint q;
    num = (longint'(corner) - longint'(origin)) * 65536;
    q = num / longint'(dir);
    if (q > longint'(T_POS_INF)) q = T_POS_INF;
    if (q < longint'(T_NEG_INF)) q = T_NEG_INF;
    return q[31:0];
  endfunction

  function automatic out_item_t trace_ray(in_item_t r);
    logic signed [31:0] pos [3];
    logic signed [31:0] dir [3];
    logic signed [31:0] tnear, tfar, t1, t2, s;
    logic [1:0] axis;
    logic neg, miss;
    out_item_t res;
    pos = '{r.ray_pos_x, r.ray_pos_y, r.ray_pos_z};
    dir = '{r.ray_dir_x, r.ray_dir_y, r.ray_dir_z};
    tnear = T_NEG_INF;
    tfar = T_POS_INF;
    axis = FACE_NONE;
    neg = 1'b0;
    miss = 1'b0;
    for (int u = 0; u < 3; u++) begin
      if (!miss) begin
        if (dir[u] == 0) begin
          if (pos[u] > box_hi[u] || pos[u] < box_lo[u]) miss = 1'b1;
        end else begin
          t1 = slab_dist(box_lo[u], pos[u], dir[u]);
          t2 = slab_dist(box_hi[u], pos[u], dir[u]);
          if (t1 > t2) begin
            s = t1; t1 = t2; t2 = s;
          end
          if (t1 > tnear) begin
            tnear = t1;
            axis = u[1:0];
            neg = dir[u] > 0;
          end
          if (t2 < tfar) tfar = t2;
          if (tnear > tfar) miss = 1'b1;
        end
      end
    end
    if (miss || !(tnear > 0)) begin
      res = '{hit: 1'b0, entry_time: '0, exit_time: '0,
              face_axis: FACE_NONE, face_negative: 1'b0};
    end else begin
      res = '{hit: 1'b1, entry_time: tnear, exit_time: tfar,
              face_axis: axis, face_negative: neg};
    end
    return res;
  endfunction

  // The request stays valid after acceptance until the next idle cycle or a drain.
  task automatic send_ray(in_item_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    hits_pending.push_back(trace_ray(r));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (hits_pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_box(logic [2:0] idx, logic signed [31:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx < REG_BOX_MAX_X) box_lo[idx] = v;
    else box_hi[idx - REG_BOX_MAX_X] = v;
  endtask

  task automatic set_box(logic signed [31:0] lx, logic signed [31:0] ly,
                         logic signed [31:0] lz, logic signed [31:0] hx,
                         logic signed [31:0] hy, logic signed [31:0] hz);
    drain();
    write_box(REG_BOX_MIN_X, lx);
    write_box(REG_BOX_MIN_Y, ly);
    write_box(REG_BOX_MIN_Z, lz);
    write_box(REG_BOX_MAX_X, hx);
    write_box(REG_BOX_MAX_Y, hy);
    write_box(REG_BOX_MAX_Z, hz);
    cfg_valid <= 1'b0;
  endtask

  function automatic in_item_t make_ray(logic signed [31:0] px, logic signed [31:0] py,
                                        logic signed [31:0] pz, logic signed [31:0] dx,
                                        logic signed [31:0] dy, logic signed [31:0] dz);
    in_item_t r;
    r = '{px, py, pz, dx, dy, dz};
    return r;
  endfunction

  // Mostly within +-10.0 (Q16.16); sometimes full 32-bit noise, zero or an extreme.
  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(9))
      0: return $urandom;
      1: return 0;
      2: return $urandom_range(1) ? T_POS_INF : T_NEG_INF;
      default: return $signed($urandom_range(20 * 65536)) - 10 * 65536;
    endcase
  endfunction

  function automatic logic signed [31:0] rand_dir();
    case ($urandom_range(9))
      0: return $urandom;
      1, 2: return 0;
      3: return $urandom_range(1) ? 32'sd1 : -32'sd1;
      default: return $signed($urandom_range(4 * 65536)) - 2 * 65536;
    endcase
  endfunction

  task automatic test_directed();
    set_box(-65536, -65536, -65536, 65536, 65536, 65536);
    send_ray(make_ray(-5 * 65536, 0, 0, 65536, 0, 0));
    send_ray(make_ray(5 * 65536, 0, 0, -65536, 0, 0));
    send_ray(make_ray(0, -5 * 65536, 0, 0, 65536, 0));
    send_ray(make_ray(0, 0, 5 * 65536, 0, 0, -65536));
    // Origins inside and outside the slabs, mostly with zero direction components.
    send_ray(make_ray(0, 3 * 65536, 0, 65536, 0, 0));
    send_ray(make_ray(0, 0, 0, 65536, 65536, 65536));
    send_ray(make_ray(0, 0, 0, 0, 0, 0));
    send_ray(make_ray(-5 * 65536, 0, 0, 0, 0, 0));
    // Ray pointing away from the box.
    send_ray(make_ray(-5 * 65536, 0, 0, -65536, 0, 0));
    // Saturating quotients, then ordinary rays that miss and hit the box.
    send_ray(make_ray(T_NEG_INF, 0, 0, 1, 0, 0));
    send_ray(make_ray(T_POS_INF, 0, 0, -1, 0, 0));
    send_ray(make_ray(T_NEG_INF, T_NEG_INF, T_NEG_INF, T_POS_INF, T_POS_INF, T_POS_INF));
    send_ray(make_ray(T_POS_INF, T_POS_INF, T_POS_INF, T_NEG_INF, T_NEG_INF, T_NEG_INF));
    send_ray(make_ray(-5 * 65536, -5 * 65536, 0, 65536, -65536, 0));
    send_ray(make_ray(-5 * 65536, -6 * 65536, -7 * 65536, 65536, 65536, 65536));
    set_box(T_NEG_INF, T_NEG_INF, T_NEG_INF, T_POS_INF, T_POS_INF, T_POS_INF);
    send_ray(make_ray(T_NEG_INF, 0, T_POS_INF, 1, -1, T_NEG_INF));
    send_ray(make_ray(0, 0, 0, T_POS_INF, 0, 0));
    send_ray(make_ray(T_POS_INF, T_NEG_INF, 0, -1, 1, 65536));
    // Inverted box.
    set_box(65536, 65536, 65536, -65536, -65536, -65536);
    send_ray(make_ray(-5 * 65536, 0, 0, 65536, 0, 0));
    send_ray(make_ray(0, 0, 0, 0, 0, 0));
    send_ray(make_ray(-5 * 65536, -5 * 65536, -5 * 65536, 65536, 65536, 65536));
  endtask

  task automatic test_random(int unsigned n);
    logic signed [31:0] c [6];
    logic signed [31:0] t;
    for (int b = 0; b < 4; b++) begin
      foreach (c[i]) c[i] = rand_coord();
      for (int i = 0; i < 3; i++)
        if (c[i] > c[i + 3] && $urandom_range(7) != 0) begin
          t = c[i]; c[i] = c[i + 3]; c[i + 3] = t;
        end
      set_box(c[0], c[1], c[2], c[3], c[4], c[5]);
      for (int k = 0; k < n / 4; k++)
        send_ray(make_ray(rand_coord(), rand_coord(), rand_coord(),
                          rand_dir(), rand_dir(), rand_dir()));
    end
  endtask

  task automatic test_backpressure();
    hold_cycles = 200;
    for (int k = 0; k < 60; k++)
      send_ray(make_ray(rand_coord(), rand_coord(), rand_coord(),
                        rand_dir(), rand_dir(), rand_dir()));
  endtask

  always @(posedge clk) begin
    if (hold_cycles != 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= $urandom_range(99) >= recv_idle_pct;
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (hits_pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result %p", out_item);
      end else begin
        want = hits_pending.pop_front();
        if (out_item !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("Mismatch: expected %p, got %p", want, out_item);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    box_lo = '{0, 0, 0};
    box_hi = '{0, 0, 0};
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_idle_pct = 20;
    recv_idle_pct = 70;
    test_directed();
    test_random(520);
    send_idle_pct = 70;
    recv_idle_pct = 20;
    test_random(520);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_backpressure();
    test_random(520);
    drain();
    if (mismatches == 0 && hits_pending.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
`default_nettype wire

### files.f
rtl/core/rbs_pkg.sv
rtl/core/rbs_slab_div.sv
rtl/core/rbs_axis_lane.sv
rtl/core/rbs_merge.sv
rtl/core/ray_box_slab_intersect_core.sv
rtl/core/rbs_checker.sv
bench/ray_box_slab_intersect_core_tb.sv
